// File: sv/agr_pkg.sv
// Package for the alternate group reverser: shared widths, defaults,
// command codes and the bank release record between front and back.
// No dependencies.
package agr_pkg;

    localparam int VALUE_W       = 32;
    localparam int GSIZE_W       = 7;
    localparam int MAX_GROUP_DEF = 16;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [GSIZE_W-1:0] GSIZE_RESET = 7'd2;

    // Command kinds carried through the queue
    localparam logic CMD_PASS = 1'b0;
    localparam logic CMD_REV  = 1'b1;

    // Back tells front that a buffer bank has been fully read out
    typedef struct packed {
        logic done;
        logic bank;
    } bank_rel_t;

endpackage

// File: sv/alternate_group_reverser.sv
// Path: a passing element goes from the command queue into the output register; a reversed
// group pops its command, reads the buffer newest first and loads the output register.
// Throughput: the front takes one request per cycle until the 4-entry command queue fills
// or both ping-pong buffer banks still hold groups being read out; the back emits one
// element per cycle while the receiver is ready, idling before a reversed group and after it.
// Reset: synchronous active-low aresetn clears phase, fill, queue and output valid.
module alternate_group_reverser import agr_pkg::*; #(
    parameter int MAX_GROUP = MAX_GROUP_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [GSIZE_W-1:0] cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [VALUE_W-1:0] s_value,
    input  logic               s_end_of_list,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [VALUE_W-1:0] m_out_value,
    output logic               m_list_done,
    output logic               m_run_last
);

    // Buffer address is {bank, slot}; each bank holds one reversing group
    localparam int CW        = $clog2(MAX_GROUP + 1);
    localparam int AW        = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int RAM_DEPTH = 2 * (1 << AW);
    // Command word: {kind, end_of_list, bank, count, value}
    localparam int CMD_W     = VALUE_W + CW + 3;

    logic [GSIZE_W-1:0] group_size_reg;

    logic             q_push, q_pop, q_empty, q_full;
    logic [CMD_W-1:0] q_data, q_head;

    logic               ram_wr_en, ram_rd_en;
    logic [AW:0]        ram_wr_addr, ram_rd_addr;
    logic [VALUE_W-1:0] ram_rd_data;

    bank_rel_t rel;

    // Group size register; to be written only while the block is idle, which the block does not enforce
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_size_reg <= GSIZE_RESET;
        end else if (cfg_wr_en) begin
            group_size_reg <= cfg_wr_data;
        end
    end

    // Front: classify each request, buffer reversing elements, queue commands
    agr_front #(
        .MAX_GROUP (MAX_GROUP)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .group_size    (group_size_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value       (s_value),
        .s_end_of_list (s_end_of_list),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_data),
        .ram_wr_en     (ram_wr_en),
        .ram_wr_addr   (ram_wr_addr),
        .rel           (rel)
    );

    // Decouple the two sides so each can stall on its own
    agr_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    // Ping-pong group buffer; contents are never cleared
    agr_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (s_value),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Back: emit passing elements, drain reversed groups newest first
    agr_back #(
        .MAX_GROUP (MAX_GROUP)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_head      (q_head),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .rel         (rel),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_value (m_out_value),
        .m_list_done (m_list_done),
        .m_run_last  (m_run_last)
    );

endmodule

// File: sv/agr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module agr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/agr_front.sv
// Front part: accepts list elements, tracks group phase and fill, writes
// reversing groups into the ping-pong buffer and queues commands.
// Depends on agr_pkg.
module agr_front import agr_pkg::*; #(
    parameter int MAX_GROUP = MAX_GROUP_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [GSIZE_W-1:0]                   group_size,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [VALUE_W-1:0]                   s_value,
    input  logic                                 s_end_of_list,
    input  logic                                 q_full,
    output logic                                 q_push,
    output logic [VALUE_W+$clog2(MAX_GROUP+1)+2:0] q_data,
    output logic                                 ram_wr_en,
    output logic [((MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1):0] ram_wr_addr,
    input  bank_rel_t                            rel
);

    localparam int CW = $clog2(MAX_GROUP + 1);
    localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam logic [CW-1:0] MAX_C  = CW'(MAX_GROUP);
    localparam logic [CW-1:0] LAST_C = CW'(MAX_GROUP - 1);

    logic          phase_reg, phase_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          bank_reg, bank_next;
    logic [1:0]    busy_reg, busy_next;

    logic [CW-1:0] k;
    logic [CW-1:0] slot;
    logic [CW-1:0] cnt;
    logic [CW-1:0] fill_inc;
    logic          blocked;
    logic          acc;
    logic          close_rev;

    // Effective group size: zero acts as one, clamp at buffer depth
    always_comb begin
        if (group_size == '0) begin
            k = CW'(1);
        end else if (group_size > GSIZE_W'(MAX_GROUP)) begin
            k = MAX_C;
        end else begin
            k = group_size[CW-1:0];
        end
    end

    assign slot      = (fill_reg >= MAX_C) ? LAST_C : fill_reg;
    assign cnt       = slot + CW'(1);
    assign fill_inc  = fill_reg + CW'(1);
    assign blocked   = !phase_reg && (fill_reg == '0) && busy_reg[bank_reg];
    assign s_ready   = !q_full && !blocked;
    assign acc       = s_valid && s_ready;
    assign close_rev = acc && !phase_reg && ((cnt >= k) || s_end_of_list);

    assign q_push = acc && (phase_reg || close_rev);
    assign q_data = {(phase_reg ? CMD_PASS : CMD_REV), s_end_of_list, bank_reg, cnt, s_value};

    assign ram_wr_en   = acc && !phase_reg;
    assign ram_wr_addr = {bank_reg, slot[AW-1:0]};

    always_comb begin
        phase_next = phase_reg;
        fill_next  = fill_reg;
        bank_next  = bank_reg;
        busy_next  = busy_reg;
        if (rel.done) begin
            busy_next[rel.bank] = 1'b0;
        end
        if (close_rev) begin
            busy_next[bank_reg] = 1'b1;
        end
        if (acc) begin
            if (phase_reg) begin
                if (fill_inc >= k) begin
                    fill_next  = '0;
                    phase_next = 1'b0;
                end else begin
                    fill_next = fill_inc;
                end
            end else if (close_rev) begin
                fill_next  = '0;
                phase_next = 1'b1;
                bank_next  = !bank_reg;
            end else begin
                fill_next = cnt;
            end
            if (s_end_of_list) begin
                fill_next  = '0;
                phase_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 1'b0;
            fill_reg  <= '0;
            bank_reg  <= 1'b0;
            busy_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            fill_reg  <= fill_next;
            bank_reg  <= bank_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

// File: sv/agr_queue.sv
// Small command queue between the front and back parts.
// Depends on agr_pkg.
module agr_queue import agr_pkg::*; #(
    parameter int WIDTH = 40,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             empty,
    output logic             full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_P = PW'(DEPTH - 1);

    logic [WIDTH-1:0] slots_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == NW'(DEPTH));
    assign head    = slots_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_P) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_P) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + NW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: sv/agr_back.sv
// Back part: pops commands, passes elements or reads a buffered group out
// newest first, and holds the result in the output register.
// Depends on agr_pkg.
module agr_back import agr_pkg::*; #(
    parameter int MAX_GROUP = MAX_GROUP_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [VALUE_W+$clog2(MAX_GROUP+1)+2:0] q_head,
    input  logic                                 q_empty,
    output logic                                 q_pop,
    output logic                                 ram_rd_en,
    output logic [((MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1):0] ram_rd_addr,
    input  logic [VALUE_W-1:0]                   ram_rd_data,
    output bank_rel_t                            rel,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [VALUE_W-1:0]                   m_out_value,
    output logic                                 m_list_done,
    output logic                                 m_run_last
);

    localparam int CW = $clog2(MAX_GROUP + 1);
    localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_REV  = 2'b10
    } back_state_t;

    back_state_t       state_reg, state_next;
    logic [CW-1:0]     rem_reg, rem_next;
    logic              bank_reg, bank_next;
    logic              eol_reg, eol_next;
    logic              pend_reg, pend_next;
    logic              pend_done_reg, pend_done_next;
    logic              pend_last_reg, pend_last_next;
    logic              m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0] m_value_reg, m_value_next;
    logic              m_done_reg, m_done_next;
    logic              m_last_reg, m_last_next;

    logic               h_kind, h_eol, h_bank;
    logic [CW-1:0]      h_cnt;
    logic [VALUE_W-1:0] h_value;
    logic [CW-1:0]      rem_m1;
    logic               out_free, issue, load_pend, load_pass, finish;

    assign {h_kind, h_eol, h_bank, h_cnt, h_value} = q_head;

    assign out_free  = !m_valid_reg || m_ready;
    assign rem_m1    = rem_reg - CW'(1);
    assign issue     = (state_reg == B_REV) && (rem_reg != '0) && (!pend_reg || out_free);
    assign load_pend = pend_reg && out_free;
    assign finish    = (state_reg == B_REV) && (rem_reg == '0) && !pend_reg;
    assign q_pop     = !q_empty && (state_reg == B_IDLE) && !pend_reg
                       && ((h_kind == CMD_REV) || out_free);
    assign load_pass = q_pop && (h_kind == CMD_PASS);

    assign ram_rd_en   = issue;
    assign ram_rd_addr = {bank_reg, rem_m1[AW-1:0]};
    assign rel.done    = finish;
    assign rel.bank    = bank_reg;

    always_comb begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        bank_next      = bank_reg;
        eol_next       = eol_reg;
        pend_next      = pend_reg;
        pend_done_next = pend_done_reg;
        pend_last_next = pend_last_reg;
        m_valid_next   = m_valid_reg;
        m_value_next   = m_value_reg;
        m_done_next    = m_done_reg;
        m_last_next    = m_last_reg;

        if (q_pop && (h_kind == CMD_REV)) begin
            state_next = B_REV;
            rem_next   = h_cnt;
            bank_next  = h_bank;
            eol_next   = h_eol;
        end
        if (finish) begin
            state_next = B_IDLE;
        end

        if (load_pend) begin
            pend_next = 1'b0;
        end
        if (issue) begin
            rem_next       = rem_m1;
            pend_next      = 1'b1;
            pend_last_next = (rem_reg == CW'(1));
            pend_done_next = eol_reg && (rem_reg == CW'(1));
        end

        if (load_pend) begin
            m_valid_next = 1'b1;
            m_value_next = ram_rd_data;
            m_done_next  = pend_done_reg;
            m_last_next  = pend_last_reg;
        end else if (load_pass) begin
            m_valid_next = 1'b1;
            m_value_next = h_value;
            m_done_next  = h_eol;
            m_last_next  = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            rem_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rem_reg     <= rem_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bank_reg      <= bank_next;
        eol_reg       <= eol_next;
        pend_done_reg <= pend_done_next;
        pend_last_reg <= pend_last_next;
        m_value_reg   <= m_value_next;
        m_done_reg    <= m_done_next;
        m_last_reg    <= m_last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_out_value = m_value_reg;
    assign m_list_done = m_done_reg;
    assign m_run_last  = m_last_reg;

endmodule

// File: sv/agr_checker.sv
// Port-level checks for the alternate group reverser, bound to the top level.
// Depends on agr_pkg.
module agr_checker import agr_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic [VALUE_W-1:0] s_value,
    input logic               s_end_of_list,
    input logic               m_valid,
    input logic               m_ready,
    input logic [VALUE_W-1:0] m_out_value,
    input logic               m_list_done,
    input logic               m_run_last
);

    // Waiting request holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_value) && $stable(s_end_of_list))
        else $error("request changed while waiting");

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_value)
            && $stable(m_list_done) && $stable(m_run_last))
        else $error("result changed while stalled");

    // Reset drops the result valid
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // End of list only on the last result of its request
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_list_done |-> m_run_last)
        else $error("list_done without run_last");

    // A reversed group drains without gaps once started
    a_group_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_run_last |=> m_valid)
        else $error("gap inside a reversed group");

endmodule

bind alternate_group_reverser agr_checker u_agr_checker (.*);

// File: dv/tb_top.sv
// Testbench for alternate_group_reverser: drives lists of values through
// the request channel and checks every reordered element against a predictor.
// Depends on agr_pkg and the alternate_group_reverser RTL.
module tb_top;
    import agr_pkg::*;

    // Buffer depth of the instance, taken from the package default
    localparam int GROUP_DEPTH    = MAX_GROUP_DEF;
    // Cycles to let pass after the last expected element before a register write
    localparam int SETTLE_CYCLES  = 8;
    // Long receiver hold-off used to fill the block and stall its input
    localparam int RX_HOLD_CYCLES = 300;
    // Cycles with no request and no element accepted before the run is abandoned
    localparam int STALL_LIMIT    = 4000;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               done;
        logic               last;
    } element_t;

    logic               aclk;
    logic               aresetn       = 1'b0;
    logic               cfg_wr_en     = 1'b0;
    logic [GSIZE_W-1:0] cfg_wr_data   = '0;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic [VALUE_W-1:0] s_value       = '0;
    logic               s_end_of_list = 1'b0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic [VALUE_W-1:0] m_out_value;
    logic               m_list_done;
    logic               m_run_last;

    // Predictor state: our own copy of the group buffer, fill count, phase and size
    logic [VALUE_W-1:0] group_store [GROUP_DEPTH];
    logic [GSIZE_W-1:0] fill_count   = '0;
    logic               passing      = 1'b0;
    logic [GSIZE_W-1:0] group_size   = GSIZE_RESET;

    // Elements still owed by the block, oldest first
    element_t pending_elements [$];

    int  error_count = 0;
    int  result_index = 0;
    int  idle_count = 0;
    bit  tx_idles = 1'b1;
    bit  rx_idles = 1'b1;
    bit  hold_req = 1'b0;

    alternate_group_reverser DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value       (s_value),
        .s_end_of_list (s_end_of_list),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_value   (m_out_value),
        .m_list_done   (m_list_done),
        .m_run_last    (m_run_last)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Size actually used: zero acts as one, anything beyond the buffer saturates
    function automatic int effective_size(logic [GSIZE_W-1:0] sz);
        if (sz == 0) return 1;
        if (sz > GROUP_DEPTH) return GROUP_DEPTH;
        return int'(sz);
    endfunction

    // Advance the predictor by one accepted request and queue the elements it releases
    function automatic void reorder_element(logic [VALUE_W-1:0] value, logic eol);
        int k;
        int slot;
        int cnt;
        element_t e;
        k = effective_size(group_size);
        if (passing) begin
            // Pass-through group: element leaves at once, alone for this request
            e.value = value;
            e.done  = eol;
            e.last  = 1'b1;
            pending_elements.push_back(e);
            fill_count = fill_count + GSIZE_W'(1);
            if (fill_count >= k) begin
                fill_count = '0;
                passing    = 1'b0;
            end
        end else begin
            slot = (fill_count >= GROUP_DEPTH) ? GROUP_DEPTH - 1 : int'(fill_count);
            group_store[slot] = value;
            fill_count = GSIZE_W'(slot + 1);
            // Close the group when full or when the list ends mid-group
            if (fill_count >= k || eol) begin
                cnt = int'(fill_count);
                for (int i = 0; i < cnt; i++) begin
                    e.value = group_store[cnt - 1 - i];
                    e.last  = (i + 1 == cnt);
                    e.done  = eol && e.last;
                    pending_elements.push_back(e);
                end
                fill_count = '0;
                passing    = 1'b1;
            end
        end
        // End of list returns the block to its reset phase
        if (eol) begin
            fill_count = '0;
            passing    = 1'b0;
        end
    endfunction

    task automatic report_mismatch(string field, logic [VALUE_W-1:0] got,
                                   logic [VALUE_W-1:0] want);
        $display("ERROR: element %0d %s got %h want %h", result_index, field, got, want);
        error_count++;
    endtask

    // Offer one request, hold it until accepted, then predict its elements.
    // Called right after a rising edge; valid stays high on return.
    task automatic send_request(logic [VALUE_W-1:0] value, logic eol);
        if (tx_idles && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_value       <= value;
        s_end_of_list <= eol;
        do @(posedge aclk); while (!s_ready);
        reorder_element(value, eol);
    endtask

    // Drop valid, wait for every owed element, then let the block settle
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_elements.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write the group size register; callers drain owed elements first, but a reversing group may be partly filled
    task automatic write_group_size(logic [GSIZE_W-1:0] sz);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= sz;
        @(posedge aclk);
        group_size = sz;
        cfg_wr_en  <= 1'b0;
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Extreme values at the reset group size of two, list ends on a lone reversed element
    task automatic test_field_extremes();
        send_request(32'h7FFF_FFFF, 1'b0);
        send_request(32'h8000_0000, 1'b0);
        send_request(32'h0000_0000, 1'b0);
        send_request(32'hFFFF_FFFF, 1'b0);
        send_request(32'h0000_0001, 1'b1);
        wait_drained();
    endtask

    // Size zero acts as one; an oversized register saturates to the buffer depth
    task automatic test_size_limits();
        write_group_size(7'd0);
        send_request(32'hAAAA_5555, 1'b0);
        send_request(32'h5555_AAAA, 1'b0);
        send_request(32'h1234_5678, 1'b1);
        wait_drained();
        write_group_size(7'h7F);
        send_request(32'h0000_0010, 1'b0);
        send_request(32'h0000_0020, 1'b0);
        send_request(32'h0000_0030, 1'b0);
        send_request(32'h0000_0040, 1'b1);
        wait_drained();
    endtask

    // List ends inside a passing group, and a list of one element
    task automatic test_partial_groups();
        write_group_size(7'd3);
        for (int i = 0; i < 5; i++) send_request(32'hC0DE_0000 + i, i == 4);
        wait_drained();
        send_request(32'hDEAD_BEEF, 1'b1);
        wait_drained();
    endtask

    // Shrink the size while a reversing group already holds more than the new size
    task automatic test_resize_mid_group();
        write_group_size(7'd8);
        for (int i = 0; i < 5; i++) send_request(32'h0BAD_0000 + i, 1'b0);
        wait_drained();
        write_group_size(7'd3);
        send_request(32'h0BAD_0005, 1'b0);
        send_request(32'h0BAD_0006, 1'b0);
        send_request(32'h0BAD_0007, 1'b1);
        wait_drained();
    endtask

    // Random lists under random sizes, with occasional pauses and mid-list resizes
    task automatic test_random_lists(int n_items);
        int sent;
        int len;
        int k;
        int pause_at;
        int resize_at;
        logic [GSIZE_W-1:0] sz;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(0, 15))
                0:       sz = 7'd0;
                1:       sz = 7'h7F;
                2:       sz = 7'd64;
                3:       sz = 7'd17;
                4:       sz = 7'd16;
                default: sz = GSIZE_W'($urandom_range(1, 6));
            endcase
            write_group_size(sz);
            k = effective_size(sz);
            case ($urandom_range(0, 3))
                0:       len = 2 * k * $urandom_range(1, 2);
                1:       len = $urandom_range(1, 4);
                default: len = $urandom_range(1, 4 * k);
            endcase
            pause_at  = ($urandom_range(0, 5) == 0 && len > 1) ? $urandom_range(1, len - 1) : -1;
            resize_at = ($urandom_range(0, 5) == 0 && len > 1) ? $urandom_range(1, len - 1) : -1;
            for (int i = 0; i < len; i++) begin
                if (i == pause_at) wait_drained();
                if (i == resize_at) begin
                    wait_drained();
                    write_group_size(GSIZE_W'($urandom_range(1, 8)));
                end
                send_request(pick_value(), i == len - 1);
            end
            sent += len;
            wait_drained();
        end
    endtask

    // Hold the receiver off for a long stretch while requests keep coming
    task automatic test_output_backpressure();
        write_group_size(7'd4);
        tx_idles = 1'b0;
        hold_req = 1'b1;
        for (int i = 0; i < 48; i++) send_request($urandom, i == 47);
        wait_drained();
        tx_idles = 1'b1;
    endtask

    // Full rate on both sides for the closing stretch
    task automatic test_full_rate();
        tx_idles = 1'b0;
        rx_idles = 1'b0;
        test_random_lists(60);
    endtask

    // Receiver: random ready bursts, plus one long hold-off on request
    initial begin : receiver
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (rx_idles && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end
    end

    // Compare each accepted element with the oldest one owed
    always @(posedge aclk) begin : element_check
        element_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_elements.size() == 0) begin
                report_mismatch("unexpected", m_out_value, '0);
            end else begin
                want = pending_elements.pop_front();
                if (m_out_value !== want.value)
                    report_mismatch("out_value", m_out_value, want.value);
                if (m_list_done !== want.done)
                    report_mismatch("list_done", m_list_done, want.done);
                if (m_run_last !== want.last)
                    report_mismatch("run_last", m_run_last, want.last);
            end
            result_index++;
        end
    end

    // Abandon the run when neither channel moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_count <= 0;
        end else if (idle_count >= STALL_LIMIT) begin
            $display("ERROR: no progress for %0d cycles", STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_field_extremes();
        test_size_limits();
        test_partial_groups();
        test_resize_mid_group();
        test_random_lists(200);
        test_output_backpressure();
        test_full_rate();
        wait_drained();
        if (error_count == 0 && pending_elements.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/agr_pkg.sv
sv/agr_ram.sv
sv/agr_front.sv
sv/agr_queue.sv
sv/agr_back.sv
sv/alternate_group_reverser.sv
sv/agr_checker.sv
dv/tb_top.sv
